### rtl/isf_pkg.sv
`default_nettype none
package isf_pkg;

	// fixed field widths
	localparam int PIXEL_W  = 8;
	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam int ENERGY_W = 41;
	localparam int FREQ_W   = 25;

	// parameter defaults
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int FRAC_BITS_DEF  = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

endpackage
`default_nettype wire

### rtl/image_spatial_frequency_top.sv
// out_valid rises after the last pixel of a frame, once stages 1 and 2, the QW-bit serial divide
//   and the root have run; QW = 17 + log2(MAX_WIDTH) + log2(MAX_HEIGHT) + 2*FRAC_BITS (73 at defaults).
// Throughput: one pixel per cycle; the serial divide and root run once per frame, and only the
//   closing pixel of the next frame stalls while that engine or the result is still busy.
// Reset: arst_n clears counters, sums, the engine and the dimensions (both 1); the row memory
//   is not cleared, row 0 of every frame writes each entry before a later row reads it.
`default_nettype none
module image_spatial_frequency_top #(
	parameter int MAX_WIDTH  = isf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = isf_pkg::MAX_HEIGHT_DEF,
	parameter int FRAC_BITS  = isf_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [isf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [isf_pkg::CFG_W-1:0]     cfg_data,
	// pixel stream
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [isf_pkg::PIXEL_W-1:0]   pixel,
	// frame result
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [isf_pkg::ENERGY_W-1:0]       gradient_energy,
	output logic [isf_pkg::FREQ_W-1:0]         frequency_q16
);

	localparam int CW    = $clog2(MAX_WIDTH);          // column index
	localparam int RW    = $clog2(MAX_HEIGHT);         // row index
	localparam int DWW   = $clog2(MAX_WIDTH + 1);      // clamped width
	localparam int DHW   = $clog2(MAX_HEIGHT + 1);     // clamped height
	localparam int NW    = DWW + DHW;                  // pixel count w*h
	localparam int SUM_W = 17 + CW + RW;               // 2*255^2 per pixel, w*h pixels
	localparam int QW    = SUM_W + 2 * FRAC_BITS;      // quotient of sum*4^F / n
	localparam int PAIRS = (QW + 1) / 2;               // root digits
	localparam int KW    = $clog2(QW);                 // step counter
	localparam int PW    = isf_pkg::PIXEL_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	// ---------------------------------------------------------------- configuration
	logic [DWW-1:0] w_q, w_clamp;
	logic [DHW-1:0] h_q, h_clamp;
	logic [NW-1:0]  n_q;
	logic           cfg_hit;

	always_comb begin
		if (cfg_data == '0) begin
			w_clamp = DWW'(1);
			h_clamp = DHW'(1);
		end else begin
			w_clamp = (32'(cfg_data) > 32'(MAX_WIDTH)) ? DWW'(MAX_WIDTH) : DWW'(cfg_data);
			h_clamp = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? DHW'(MAX_HEIGHT) : DHW'(cfg_data);
		end
	end

	// any write to a listed register restarts the frame
	assign cfg_hit = cfg_we &&
		(cfg_index == isf_pkg::REG_IMAGE_WIDTH || cfg_index == isf_pkg::REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= DWW'(1);
			h_q <= DHW'(1);
		end else if (cfg_we) begin
			if (cfg_index == isf_pkg::REG_IMAGE_WIDTH)  w_q <= w_clamp;
			if (cfg_index == isf_pkg::REG_IMAGE_HEIGHT) h_q <= h_clamp;
		end
	end

	// pixel count; dimensions are static while a frame runs
	always_ff @(posedge clk) begin
		n_q <= NW'(w_q) * NW'(h_q);
	end

	// ---------------------------------------------------------------- raster counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] left_q;
	logic          last_col, last_row, last_px;
	logic          in_xfer;
	logic          fin_busy;
	logic [1:0]    state_q;
	logic          v_s1, last_s1, hl_s1, hu_s1;
	logic          v_s2, last_s2;

	assign last_col = ((DWW + 1)'(col_q) + 1'b1) == (DWW + 1)'(w_q);
	assign last_row = ((DHW + 1)'(row_q) + 1'b1) == (DHW + 1)'(h_q);
	assign last_px  = last_col && last_row;

	// only a frame-closing pixel waits for the finishing engine
	assign fin_busy = (v_s1 && last_s1) || (v_s2 && last_s2) || (state_q != ST_IDLE);
	assign in_stall = fin_busy && last_px;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (cfg_hit) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (in_xfer) begin
			left_q <= pixel;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- row memory
	// read-before-write on the same entry: a width of one still sees the pixel above
	logic [PW-1:0] prev_row_mem [MAX_WIDTH];
	logic [PW-1:0] up_s1;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			up_s1 <= prev_row_mem[col_q];
			prev_row_mem[col_q] <= pixel;
		end
	end

	// ---------------------------------------------------------------- stage 1: squares
	logic [PW-1:0]   pix_s1, left_s1;
	logic [PW-1:0]   dh, dv;
	logic [2*PW-1:0] sqh, sqv;
	logic [2*PW-1:0] sqh_s2, sqv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1  <= pixel;
			left_s1 <= left_q;
			hl_s1   <= col_q != '0;
			hu_s1   <= row_q != '0;
			last_s1 <= last_px;
		end
	end

	always_comb begin
		dh  = (pix_s1 >= left_s1) ? pix_s1 - left_s1 : left_s1 - pix_s1;
		dv  = (pix_s1 >= up_s1) ? pix_s1 - up_s1 : up_s1 - pix_s1;
		sqh = hl_s1 ? (2*PW)'(dh) * (2*PW)'(dh) : '0;
		sqv = hu_s1 ? (2*PW)'(dv) * (2*PW)'(dv) : '0;
	end

	// ---------------------------------------------------------------- stage 2: accumulate
	logic [SUM_W-1:0] energy_q, energy_nxt, total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s2    <= v_s1;
			last_s2 <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sqh_s2 <= sqh;
			sqv_s2 <= sqv;
		end
	end

	assign energy_nxt = energy_q + SUM_W'(sqh_s2) + SUM_W'(sqv_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
		end else if (cfg_hit) begin
			energy_q <= '0;
		end else if (v_s2) begin
			energy_q <= last_s2 ? '0 : energy_nxt;
		end
	end

	// ---------------------------------------------------------------- divide and root
	// Q = floor(sum * 4^F / n), then root = floor(sqrt(Q))
	logic [KW-1:0]      cnt_q;
	logic [QW-1:0]      num_q, num_nxt;
	logic [NW-1:0]      rem_q, rem_nxt;
	logic [NW:0]        dshift, dsub;
	logic               dge;
	logic [2*PAIRS-1:0] rad_q;
	logic [PAIRS-1:0]   root_q, root_nxt, srem_q, srem_nxt;
	logic [PAIRS+1:0]   sshift, strial, ssub;
	logic               sge;
	logic [63:0]        root_ext, energy_ext;
	logic [isf_pkg::FREQ_W-1:0] freq_q;

	always_comb begin
		dshift  = {rem_q, num_q[QW-1]};
		dsub    = dshift - {1'b0, n_q};
		dge     = dshift >= {1'b0, n_q};
		rem_nxt = dge ? dsub[NW-1:0] : dshift[NW-1:0];
		num_nxt = {num_q[QW-2:0], dge};

		sshift   = {srem_q, rad_q[2*PAIRS-1 -: 2]};
		strial   = {root_q, 2'b01};
		ssub     = sshift - strial;
		sge      = sshift >= strial;
		srem_nxt = sge ? ssub[PAIRS-1:0] : sshift[PAIRS-1:0];
		root_nxt = {root_q[PAIRS-2:0], sge};
	end

	assign root_ext = 64'(root_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (v_s2 && last_s2) begin
						state_q <= ST_DIV;
						cnt_q   <= KW'(QW - 1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= KW'(PAIRS - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (v_s2 && last_s2) begin
					total_q <= energy_nxt;
					num_q   <= {energy_nxt, (2 * FRAC_BITS)'(0)};
					rem_q   <= '0;
				end
			end
			ST_DIV: begin
				num_q <= num_nxt;
				rem_q <= rem_nxt;
				if (cnt_q == '0) begin
					rad_q  <= (2 * PAIRS)'(num_nxt);
					root_q <= '0;
					srem_q <= '0;
				end
			end
			ST_SQRT: begin
				rad_q  <= rad_q << 2;
				root_q <= root_nxt;
				srem_q <= srem_nxt;
				if (cnt_q == '0) freq_q <= root_ext[isf_pkg::FREQ_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- result
	assign energy_ext      = 64'(total_q);
	assign out_valid       = state_q == ST_OUT;
	assign gradient_energy = energy_ext[isf_pkg::ENERGY_W-1:0];
	assign frequency_q16   = freq_q;

endmodule
`default_nettype wire

### rtl/isf_checker.sv
`default_nettype none
module isf_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [isf_pkg::ENERGY_W-1:0]  gradient_energy,
	input wire logic [isf_pkg::FREQ_W-1:0]    frequency_q16
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// and its payload holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(gradient_energy) && $stable(frequency_q16))
		else $error("result payload changed while stalled");

	// a transfer returns the engine to idle, so results never come back to back
	a_no_b2b: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result offered right after a transfer");

	// zero energy gives zero frequency
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gradient_energy == '0 |-> frequency_q16 == '0)
		else $error("nonzero frequency for zero energy");

endmodule

bind image_spatial_frequency_top isf_checker u_isf_checker (.*);
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

	localparam int MAX_W = isf_pkg::MAX_WIDTH_DEF;
	localparam int MAX_H = isf_pkg::MAX_HEIGHT_DEF;
	// A result needs the divide and root after the last pixel, so leave room for them at default sizes.
	localparam int SETTLE_CYCLES = 200;
	// Output hold-off, long enough that the block backs up and stalls the pixel input.
	localparam int LONG_HOLD = 1500;
	localparam int RANDOM_ITEMS = 1800;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int MAX_REPORTS = 40;

	// indexes past the register list, writes there must be dropped
	localparam logic [isf_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [isf_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_ANY, IDLE_RARE} idle_mode_t;
	typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_SMOOTH, PIX_FLAT} pix_style_t;

	typedef struct {
		bit [isf_pkg::PIXEL_W-1:0] value;
		int unsigned               gap;
	} feed_item_t;

	typedef struct {
		bit [isf_pkg::ENERGY_W-1:0] energy;
		bit [isf_pkg::FREQ_W-1:0]   freq;
	} frame_total_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [isf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [isf_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [isf_pkg::PIXEL_W-1:0]   pixel = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [isf_pkg::ENERGY_W-1:0]  gradient_energy;
	logic [isf_pkg::FREQ_W-1:0]    frequency_q16;

	image_spatial_frequency_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pixel           (pixel),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.gradient_energy (gradient_energy),
		.frequency_q16   (frequency_q16)
	);

	// Pixels waiting to be offered, and frame totals waiting to come out.
	feed_item_t   pixel_feed[$];
	frame_total_t due_frames[$];

	// Stimulus knobs, written only by the sequencing process.
	idle_mode_t                tx_mode = IDLE_NONE;
	idle_mode_t                rx_mode = IDLE_NONE;
	bit [isf_pkg::PIXEL_W-1:0] pix_base = '0;
	logic                      hold_go = 1'b0;

	// Shadow of the metric: previous row, left neighbor, position and running energy.
	bit [isf_pkg::PIXEL_W-1:0] row_mem [0:MAX_W-1];
	bit [isf_pkg::PIXEL_W-1:0] left_px;
	int unsigned               col_pos;
	int unsigned               row_pos;
	bit [41:0]                 energy_acc;
	bit [isf_pkg::CFG_W-1:0]   img_w = 13'd1;
	bit [isf_pkg::CFG_W-1:0]   img_h = 13'd1;

	// bookkeeping
	int     fails = 0;
	int     frames_checked = 0;
	int     pixels_sent = 0;
	int     stalled_cycles = 0;
	int     reg_writes = 0;
	int     feed_wait = 0;
	int     rx_wait = 0;
	int     hold_left = 0;
	longint cycle_count = 0;
	bit [isf_pkg::FREQ_W-1:0] top_freq = '0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// 0 acts as 1, anything past the cap (row memory size or height limit) acts as the cap
	function automatic int unsigned eff_dim(input bit [isf_pkg::CFG_W-1:0] v,
		input int unsigned cap);
		if (v == 0) return 1;
		if (v > cap) return cap;
		return v;
	endfunction

	// floor(sqrt(e / n) * 2^16) == floor(sqrt(floor(e * 2^32 / n))), found bit by bit.
	function automatic bit [isf_pkg::FREQ_W-1:0] spatial_freq_q16(input bit [41:0] e,
		input int unsigned n);
		bit [79:0] scaled;
		bit [79:0] root;
		bit [79:0] trial;
		scaled = ({38'd0, e} << (2 * isf_pkg::FRAC_BITS_DEF)) / 80'(n);
		root = '0;
		for (int i = 39; i >= 0; i--) begin
			trial = root | (80'd1 << i);
			if (trial * trial <= scaled) root = trial;
		end
		return root[isf_pkg::FREQ_W-1:0];
	endfunction

	function automatic void restart_model();
		left_px = '0;
		col_pos = 0;
		row_pos = 0;
		energy_acc = '0;
	endfunction

	// One accepted pixel; closes the frame and queues its totals on the last one.
	function automatic void account_pixel(input bit [isf_pkg::PIXEL_W-1:0] px);
		int unsigned  w_eff;
		int unsigned  h_eff;
		int           d;
		frame_total_t done;
		w_eff = eff_dim(img_w, MAX_W);
		h_eff = eff_dim(img_h, MAX_H);
		if (col_pos > 0) begin
			d = int'(px) - int'(left_px);
			energy_acc += 42'(d * d);
		end
		if (row_pos > 0) begin
			d = int'(px) - int'(row_mem[col_pos]);
			energy_acc += 42'(d * d);
		end
		row_mem[col_pos] = px;
		left_px = px;
		if (col_pos + 1 >= w_eff) begin
			col_pos = 0;
			left_px = '0;
			if (row_pos + 1 >= h_eff) begin
				done.energy = energy_acc[isf_pkg::ENERGY_W-1:0];
				done.freq = spatial_freq_q16(energy_acc, w_eff * h_eff);
				due_frames.push_back(done);
				restart_model();
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endfunction

	function automatic int unsigned draw_idle(input idle_mode_t m);
		case (m)
		IDLE_ANY: return $urandom_range(0, 17);
		IDLE_RARE: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
		default: return 0;
		endcase
	endfunction

	function automatic bit [isf_pkg::PIXEL_W-1:0] draw_pixel(input pix_style_t style);
		int v;
		case (style)
		PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		PIX_SMOOTH: begin
			v = int'(pix_base) + int'($urandom_range(0, 8)) - 4;
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			return 8'(v);
		end
		PIX_FLAT: return pix_base;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic feed(input bit [isf_pkg::PIXEL_W-1:0] v);
		feed_item_t it;
		it.value = v;
		it.gap = draw_idle(tx_mode);
		pixel_feed.push_back(it);
	endtask

	task automatic feed_pixels(input int count, input pix_style_t style);
		for (int i = 0; i < count; i++) feed(draw_pixel(style));
	endtask

	// Every queued pixel transferred and every frame total received; looked at mid-cycle,
	// once the clock-edge updates have settled.
	task automatic wait_drained();
		do @(negedge clk); while (pixel_feed.size() != 0 || in_valid || due_frames.size() != 0);
	endtask

	// Drained, then long enough that a frame-less tail cannot still be in the engine.
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Called only with the block idle, so the shadow may follow at once.
	task automatic write_reg(input logic [isf_pkg::CFG_IDX_W-1:0] idx,
		input logic [isf_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == isf_pkg::REG_IMAGE_WIDTH) begin
			img_w = val;
			restart_model();
		end else if (idx == isf_pkg::REG_IMAGE_HEIGHT) begin
			img_h = val;
			restart_model();
		end
		reg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_dims(input int w, input int h);
		if ($urandom_range(0, 1)) begin
			write_reg(isf_pkg::REG_IMAGE_WIDTH, isf_pkg::CFG_W'(w));
			write_reg(isf_pkg::REG_IMAGE_HEIGHT, isf_pkg::CFG_W'(h));
		end else begin
			write_reg(isf_pkg::REG_IMAGE_HEIGHT, isf_pkg::CFG_W'(h));
			write_reg(isf_pkg::REG_IMAGE_WIDTH, isf_pkg::CFG_W'(w));
		end
	endtask

	// Pixel driver: holds a stalled transfer, otherwise waits out the item's gap and offers it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				account_pixel(pixel);
				pixels_sent++;
			end
			if (in_valid && in_stall) begin
				stalled_cycles++;
			end else if (pixel_feed.size() != 0 && feed_wait >= pixel_feed[0].gap) begin
				in_valid <= 1'b1;
				pixel <= pixel_feed[0].value;
				void'(pixel_feed.pop_front());
				feed_wait = 0;
			end else begin
				in_valid <= 1'b0;
				if (pixel_feed.size() != 0) feed_wait++;
			end
		end
	end

	// Result monitor: checks each transfer against the oldest predicted frame, then
	// stalls the next result for a drawn number of cycles (or for the long hold).
	always @(posedge clk) begin
		frame_total_t exp_t;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_frames.size() == 0) begin
					if (fails < MAX_REPORTS)
						$display("%0t: result with no frame pending, gradient_energy %0d frequency_q16 %0d",
							$time, gradient_energy, frequency_q16);
					fails++;
				end else begin
					exp_t = due_frames.pop_front();
					if (gradient_energy !== exp_t.energy) begin
						if (fails < MAX_REPORTS)
							$display("%0t: frame %0d gradient_energy expected %0d got %0d",
								$time, frames_checked, exp_t.energy, gradient_energy);
						fails++;
					end
					if (frequency_q16 !== exp_t.freq) begin
						if (fails < MAX_REPORTS)
							$display("%0t: frame %0d frequency_q16 expected %0d got %0d",
								$time, frames_checked, exp_t.freq, frequency_q16);
						fails++;
					end
					if (exp_t.freq > top_freq) top_freq = exp_t.freq;
				end
				frames_checked++;
			end
			if (hold_go) hold_left = LONG_HOLD;
			if (out_valid && !out_stall) rx_wait = draw_idle(rx_mode);
			else if (out_valid && rx_wait > 0) rx_wait--;
			if (hold_left > 0) hold_left--;
			out_stall <= (hold_left > 0) || (rx_wait > 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d frame results still pending",
				cycle_count, due_frames.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int         w_set;
		int         h_set;
		int         area;
		int         frames;
		int         tail;
		int         phase;
		int         random_items;
		pix_style_t style;

		restart_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions are 1x1: every pixel closes a frame with zero energy.
		feed(8'h00);
		feed(8'hFF);
		settle();

		// 2x2 checkerboard of the extremes gives the largest gradient per pixel.
		set_dims(2, 2);
		feed(8'h00);
		feed(8'hFF);
		feed(8'hFF);
		feed(8'h00);
		settle();

		// Width 0 behaves as a single column; only vertical differences count.
		set_dims(0, 3);
		feed(8'hFF);
		feed(8'h00);
		feed(8'hFF);
		settle();

		// Height 0 behaves as one row. A write to an unused index in mid-frame
		// must neither take effect nor restart the frame.
		set_dims(3, 0);
		feed(8'd10);
		settle();
		write_reg(REG_SPARE_2, 13'h1FFF);
		feed(8'd200);
		feed(8'd37);
		settle();

		// Two pixels of a frame, then a real register write restarts it.
		feed(8'd1);
		feed(8'd2);
		settle();
		write_reg(REG_SPARE_3, 13'h0000);
		write_reg(isf_pkg::REG_IMAGE_WIDTH, 13'd3);
		feed(8'd90);
		feed(8'd91);
		feed(8'd255);
		settle();

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			tx_mode = idle_mode_t'($urandom_range(0, 2));
			rx_mode = idle_mode_t'($urandom_range(0, 2));
			pix_base = 8'($urandom_range(0, 255));
			style = pix_style_t'($urandom_range(0, 3));
			case (phase)
			0: begin
				// Tiny frames back to back while the output is held off: the
				// block fills up and has to stall the pixel input.
				tx_mode = IDLE_NONE;
				rx_mode = IDLE_NONE;
				set_dims(2, 1);
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
				feed_pixels(60, PIX_RANDOM);
				random_items += 60;
			end
			3: begin
				// Sender goes quiet mid-frame until everything sent so far is out.
				set_dims(4, 3);
				feed_pixels(17, style);
				wait_drained();
				feed_pixels(19, style);
				random_items += 36;
			end
			6: begin
				// Width past the row memory acts as the full 4096; part of a row,
				// left open and dropped by the next register write.
				tx_mode = IDLE_RARE;
				set_dims(8191, 2);
				feed_pixels(150, PIX_RANDOM);
				random_items += 150;
			end
			9: begin
				// Height past the limit acts as 4096 rows of one column; the frame
				// is left open.
				tx_mode = IDLE_RARE;
				set_dims(1, 5000);
				feed_pixels(150, PIX_SMOOTH);
				random_items += 150;
			end
			default: begin
				case ($urandom_range(0, 9))
				0: begin
					w_set = $urandom_range(0, 1);
					h_set = $urandom_range(0, 1);
				end
				7: begin
					w_set = $urandom_range(13, 64);
					h_set = $urandom_range(1, 4);
				end
				8: begin
					w_set = $urandom_range(1, 4);
					h_set = $urandom_range(9, 40);
				end
				default: begin
					w_set = $urandom_range(1, 12);
					h_set = $urandom_range(1, 8);
				end
				endcase
				set_dims(w_set, h_set);
				area = eff_dim(isf_pkg::CFG_W'(w_set), MAX_W) *
					eff_dim(isf_pkg::CFG_W'(h_set), MAX_H);
				frames = $urandom_range(1, (area >= 160) ? 1 : 160 / area);
				if (frames > 24) frames = 24;
				feed_pixels(frames * area, style);
				tail = 0;
				// Now and then leave a frame unfinished; the next write discards it.
				if (area > 1 && $urandom_range(0, 3) == 0) begin
					tail = $urandom_range(1, area - 1);
					feed_pixels(tail, style);
				end
				random_items += frames * area + tail;
			end
			endcase
			settle();
			phase++;
		end

		$display("Run covered %0d frames from %0d pixel transfers across %0d register writes.",
			frames_checked, pixels_sent, reg_writes);
		$display("Pixel input stalled for %0d cycles; highest frequency_q16 seen was %0d.",
			stalled_cycles, top_freq);
		if (fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
